[rtl/assert_macros.svh]
// assertion helpers, empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_SAME_CYCLE(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

`define ASSERT_NEXT_CYCLE(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`else

`define ASSERT_SAME_CYCLE(label, clk, rst, cond, expr, msg)

`define ASSERT_NEXT_CYCLE(label, clk, rst, cond, expr, msg)

`endif

`endif

[rtl/npl_pkg.sv]
package npl_pkg;

   localparam int VALUE_W = 32;
   localparam int INDEX_W = 10;
   localparam int COUNT_W = 11;

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } op_type;

   typedef struct packed {
      op_type                     cmd;
      logic [INDEX_W-1:0]         entry_index;
      logic signed [VALUE_W-1:0]  point_x;
      logic signed [VALUE_W-1:0]  point_y;
      logic signed [VALUE_W-1:0]  query_x;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  result_y;
      logic [INDEX_W-1:0]         result_index;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROBE,
      ST_FETCH_LO,
      ST_FETCH_HI,
      ST_PICK,
      ST_RESPOND
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_write;
      logic query_start;
      logic probe;
      logic fetch_lo;
      logic fetch_hi;
      logic pick;
      logic respond;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic no_probe;
      logic last_probe;
   } sts_type;

endpackage

[rtl/npl_ram.sv]
module npl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/npl_ctrl.sv]
module npl_ctrl import npl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  op_type  req_cmd,
   input  sts_type sts,
   output ctl_type ctl,
   output logic    busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_cmd == CMD_QUERY) begin
                  ctl.query_start = 1'b1;
                  state_in        = sts.no_probe ? ST_FETCH_LO : ST_PROBE;
               end else begin
                  ctl.load_write = 1'b1;
               end
            end
         end
         ST_PROBE: begin
            ctl.probe = 1'b1;
            if (sts.last_probe) begin
               state_in = ST_FETCH_LO;
            end
         end
         ST_FETCH_LO: begin
            ctl.fetch_lo = 1'b1;
            state_in     = ST_FETCH_HI;
         end
         ST_FETCH_HI: begin
            ctl.fetch_hi = 1'b1;
            state_in     = ST_PICK;
         end
         ST_PICK: begin
            ctl.pick = 1'b1;
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            ctl.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

[rtl/npl_datapath.sv]
module npl_datapath import npl_pkg::*; #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  req_type            req_data,
   input  ctl_type            ctl,
   output sts_type            sts,
   input  logic               csr_write,
   input  logic [COUNT_W-1:0] csr_data,
   output logic               rsp_valid,
   output rsp_type            rsp_data
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int LW = AW + 1;

   // exact magnitude of a - b
   function automatic logic [VALUE_W:0] abs_diff(input logic signed [VALUE_W-1:0] a,
                                                 input logic signed [VALUE_W-1:0] b);
      logic signed [VALUE_W:0] d;
      d = $signed({a[VALUE_W-1], a}) - $signed({b[VALUE_W-1], b});
      return d[VALUE_W] ? (VALUE_W+1)'(-d) : (VALUE_W+1)'(d);
   endfunction

   logic [COUNT_W-1:0]        count_ff;
   logic signed [VALUE_W-1:0] q_ff;
   logic [LW-1:0]             len_ff;
   logic [AW-1:0]             pos_ff;
   logic [AW-1:0]             ss_ff;
   logic                      pend_ff;
   logic [AW-1:0]             pend_ss_ff;
   logic [VALUE_W:0]          dlo_ff;
   logic                      lo_le_ff;
   logic                      at_end_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff;

   logic [LW-1:0]             len_c;
   logic [AW-1:0]             len_m1;
   logic [AW-1:0]             ss0;
   logic signed [VALUE_W-1:0] rd_x;
   logic [VALUE_W-1:0]        rd_y;
   logic                      x_le_q;
   logic [AW-1:0]             pos_cur;
   logic [LW-1:0]             cand;
   logic [AW-1:0]             x_addr;
   logic [AW-1:0]             y_addr;
   logic [AW-1:0]             pos_next;
   logic [VALUE_W:0]          dhi;
   logic                      keep_lo;
   logic                      wr_en;
   logic [AW-1:0]             wr_addr;

   // clamp the configured count into 1..depth
   always_comb begin
      if (count_ff == '0) begin
         len_c = LW'(1);
      end else if (32'(count_ff) > TABLE_DEPTH) begin
         len_c = LW'(TABLE_DEPTH);
      end else begin
         len_c = LW'(count_ff);
      end
   end

   // first search stride: highest power of two not above len - 1
   assign len_m1 = AW'(len_c - LW'(1));
   always_comb begin
      ss0 = '0;
      for (int b = 0; b < AW; b++) begin
         if (len_m1[b]) begin
            ss0    = '0;
            ss0[b] = 1'b1;
         end
      end
   end

   assign x_le_q  = ($signed(rd_x) <= q_ff);
   // resolve the probe whose read data arrives this cycle
   assign pos_cur = pos_ff + ((pend_ff && x_le_q) ? pend_ss_ff : '0);
   assign cand    = LW'(pos_cur) + LW'(ss_ff);
   assign pos_next = pos_ff + AW'(1);

   assign dhi     = abs_diff(q_ff, rd_x);
   assign keep_lo = !lo_le_ff || at_end_ff || (dlo_ff < dhi);
   assign y_addr  = keep_lo ? pos_ff : pos_next;

   always_comb begin
      if (ctl.probe) begin
         x_addr = cand[AW-1:0];
      end else if (ctl.fetch_hi) begin
         x_addr = pos_next;
      end else begin
         x_addr = pos_cur;
      end
   end

   assign wr_en   = ctl.load_write && ({22'b0, req_data.entry_index} < 32'(TABLE_DEPTH));
   assign wr_addr = AW'(req_data.entry_index);

   npl_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_DEPTH)) u_x_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.point_x),
      .rd_addr (x_addr),
      .rd_data (rd_x)
   );

   npl_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_DEPTH)) u_y_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.point_y),
      .rd_addr (y_addr),
      .rd_data (rd_y)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= COUNT_W'(1);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            count_ff <= csr_data;
         end
         if (ctl.query_start || ctl.fetch_lo) begin
            pend_ff <= 1'b0;
         end else if (ctl.probe) begin
            pend_ff <= (cand < len_ff);
         end
         rsp_valid_ff <= ctl.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.query_start) begin
         q_ff   <= req_data.query_x;
         len_ff <= len_c;
         pos_ff <= '0;
         ss_ff  <= ss0;
      end
      if (ctl.probe) begin
         pos_ff     <= pos_cur;
         pend_ss_ff <= ss_ff;
         ss_ff      <= ss_ff >> 1;
      end
      if (ctl.fetch_lo) begin
         pos_ff <= pos_cur;
      end
      if (ctl.fetch_hi) begin
         lo_le_ff  <= x_le_q;
         dlo_ff    <= abs_diff(q_ff, rd_x);
         at_end_ff <= (LW'(pos_ff) == len_ff - LW'(1));
      end
      if (ctl.pick) begin
         pos_ff <= y_addr;
      end
      if (ctl.respond) begin
         rsp_ff.result_y     <= rd_y;
         rsp_ff.result_index <= INDEX_W'(pos_ff);
      end
   end

   assign sts.no_probe   = (ss0 == '0);
   assign sts.last_probe = (ss_ff == AW'(1));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/nearest_point_table_lookup_core.sv]
// load: no result; busy stays low so loads can stream every cycle
// query: any probe states of the binary search, then fetch_lo, fetch_hi, pick and respond, then rsp_valid;
// the next query is accepted in the cycle rsp_valid shows;
// the binary search makes one table read per cycle
// reset: synchronous, returns to idle and sets entry_count to 1; table undefined until loaded
`include "assert_macros.svh"

module nearest_point_table_lookup_core import npl_pkg::*; #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_data,
   output logic               rsp_valid,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_data
);

   ctl_type ctl;
   sts_type sts;
   logic    query_accept;
   logic    load_accept;

   assign csr_ready = 1'b1;

   npl_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_data.cmd),
      .sts     (sts),
      .ctl     (ctl),
      .busy    (busy)
   );

   npl_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctl       (ctl),
      .sts       (sts),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign query_accept = start && !busy && (req_data.cmd == CMD_QUERY);
   assign load_accept  = start && !busy && (req_data.cmd == CMD_LOAD);

   `ASSERT_SAME_CYCLE(a_rsp_when_idle, clock, reset, rsp_valid, !busy, "result while busy")
   `ASSERT_NEXT_CYCLE(a_query_busy, clock, reset, query_accept, busy, "query did not start")
   `ASSERT_NEXT_CYCLE(a_load_no_busy, clock, reset, load_accept, !busy && !rsp_valid, "load busy")
   `ASSERT_SAME_CYCLE(a_rsp_after_work, clock, reset, rsp_valid, $past(busy), "result without query")

endmodule

[dv/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import npl_pkg::*;

   localparam int DEPTH = 1024;
   localparam int MAX_GAP = 13;
   localparam int SETTLE_CYCLES = 20;
   localparam int DRAIN_LIMIT = 400;
   localparam logic signed [VALUE_W-1:0] V_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] V_MAX = 32'sh7FFF_FFFF;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   req_type            req_data;
   logic               rsp_valid;
   rsp_type            rsp_data;
   logic               csr_valid;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_data;

   // shadow copy of the point table and the count register
   logic signed [VALUE_W-1:0] x_tab [DEPTH];
   logic signed [VALUE_W-1:0] y_tab [DEPTH];
   logic [COUNT_W-1:0]        count_reg;
   rsp_type                   pending_lookups [$];
   int                        mismatch_count;
   bit                        no_gaps;

   nearest_point_table_lookup_core u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(string msg);
      if (mismatch_count < 50) begin
         $display("mismatch at %0t: %s", $time, msg);
      end
      mismatch_count++;
   endtask

   function automatic int active_len();
      if (count_reg == 0) return 1;
      if (count_reg > DEPTH) return DEPTH;
      return int'(count_reg);
   endfunction

   function automatic logic signed [VALUE_W-1:0] clip_value(longint v);
      if (v > longint'(V_MAX)) return V_MAX;
      if (v < longint'(V_MIN)) return V_MIN;
      return v[VALUE_W-1:0];
   endfunction

   // power-of-two search for the last x <= qx, then the nearer neighbour, ties right
   function automatic rsp_type predict_nearest(logic signed [VALUE_W-1:0] qx);
      int      len;
      int      steps;
      int      pos;
      int      span;
      longint  d_lo;
      longint  d_hi;
      rsp_type r;
      len = active_len();
      steps = 0;
      while ((1 << steps) < len) steps++;
      pos = 0;
      for (int i = steps - 1; i >= 0; i--) begin
         span = 1 << i;
         if (pos + span < len && x_tab[pos + span] <= qx) pos += span;
      end
      if (x_tab[pos] <= qx && pos != len - 1) begin
         d_lo = longint'(qx) - longint'(x_tab[pos]);
         d_hi = longint'(x_tab[pos + 1]) - longint'(qx);
         if (d_hi < 0) d_hi = -d_hi;
         if (d_lo >= d_hi) pos++;
      end
      r.result_y = y_tab[pos];
      r.result_index = pos[INDEX_W-1:0];
      return r;
   endfunction

   function automatic req_type load_item(int idx, logic signed [VALUE_W-1:0] px,
                                         logic signed [VALUE_W-1:0] py);
      req_type item;
      item.cmd = CMD_LOAD;
      item.entry_index = idx[INDEX_W-1:0];
      item.point_x = px;
      item.point_y = py;
      item.query_x = $urandom;
      return item;
   endfunction

   function automatic req_type query_item(logic signed [VALUE_W-1:0] qx);
      req_type item;
      item.cmd = CMD_QUERY;
      item.entry_index = INDEX_W'($urandom);
      item.point_x = $urandom;
      item.point_y = $urandom;
      item.query_x = qx;
      return item;
   endfunction

   // lookup values aimed at the stored points: hits, midpoints, near misses, outside, random and extremes
   function automatic logic signed [VALUE_W-1:0] pick_query(int len);
      int     i;
      int     k;
      longint lo;
      longint hi;
      i = $urandom_range(0, len - 1);
      k = $urandom_range(0, 99);
      lo = longint'(x_tab[i]);
      hi = (i + 1 < len) ? longint'(x_tab[i + 1]) : lo;
      if (k < 25) return x_tab[i];
      if (k < 50) return clip_value(((lo + hi) >>> 1) + int'($urandom_range(0, 1)));
      if (k < 65) return clip_value(lo + int'($urandom_range(0, 8)) - 4);
      if (k < 70) return clip_value(longint'(x_tab[0]) - int'($urandom_range(1, 100)));
      if (k < 75) return clip_value(longint'(x_tab[len - 1]) + int'($urandom_range(1, 100)));
      if (k < 90) return $urandom;
      return (k < 95) ? V_MIN : V_MAX;
   endfunction

   task automatic send_item(req_type item);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      // transfer done at this edge
      if (item.cmd == CMD_LOAD) begin
         x_tab[item.entry_index] = item.point_x;
         y_tab[item.entry_index] = item.point_y;
      end else begin
         pending_lookups.push_back(predict_nearest(item.query_x));
      end
   endtask

   task automatic write_count(logic [COUNT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      count_reg = value;
   endtask

   // drain outstanding lookups, then let a trailing load settle
   task automatic end_phase();
      int waited;
      start <= 1'b0;
      waited = 0;
      while (pending_lookups.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_lookups.size() != 0) begin
         report_mismatch($sformatf("%0d lookups never answered", pending_lookups.size()));
         pending_lookups.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_table(int n, bit spread, bit ordered);
      int     vals [$];
      int     j;
      int     t;
      longint pos;
      if (spread) begin
         for (int i = 0; i < n; i++) vals.push_back($urandom);
         if (ordered) begin
            vals.sort();
            for (int i = 1; i < n; i++) begin
               if (vals[i] <= vals[i - 1]) vals[i] = vals[i - 1] + 1;
            end
         end
      end else begin
         // tight cluster, ascending by construction
         pos = longint'($urandom_range(0, 32'hFFFF_FFFF - n * 1024)) + longint'(V_MIN);
         for (int i = 0; i < n; i++) begin
            vals.push_back(int'(pos));
            pos = pos + int'($urandom_range(1, 1024));
         end
         if (!ordered) begin
            for (int i = 0; i < n; i++) begin
               j = $urandom_range(0, n - 1);
               t = vals[i];
               vals[i] = vals[j];
               vals[j] = t;
            end
         end
      end
      for (int i = 0; i < n; i++) send_item(load_item(i, vals[i], $urandom));
   endtask

   task automatic run_lookups(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 11) == 0) begin
            send_item(load_item($urandom_range(0, DEPTH - 1), $urandom, $urandom));
         end else begin
            send_item(query_item(pick_query(active_len())));
         end
      end
   endtask

   task automatic test_directed();
      // one point at the reset count
      send_item(load_item(0, 32'sh0001_0000, V_MIN));
      send_item(query_item(V_MIN));
      send_item(query_item(V_MAX));
      send_item(query_item(32'sh0001_0000));
      end_phase();
      // zero count behaves as one
      write_count(COUNT_W'(0));
      send_item(query_item(32'sh0000_8000));
      end_phase();
      write_count(COUNT_W'(4));
      send_item(load_item(0, V_MIN, 32'sd1));
      send_item(load_item(1, -32'sd10, 32'sd2));
      send_item(load_item(2, 32'sd10, 32'sd3));
      send_item(load_item(3, V_MAX, V_MAX));
      send_item(query_item(V_MIN));
      send_item(query_item(-32'sd11));
      send_item(query_item(-32'sd5));
      send_item(query_item(32'sd0));
      send_item(query_item(32'sd5));
      send_item(query_item(32'sd1073741828));
      send_item(query_item(V_MAX));
      end_phase();
      // neighbours at both ends of the range, full-width distances
      write_count(COUNT_W'(2));
      send_item(load_item(1, V_MAX, -32'sd1));
      send_item(query_item(-32'sd1));
      send_item(query_item(32'sd0));
      end_phase();
   endtask

   task automatic test_full_table();
      write_count(COUNT_W'(DEPTH));
      load_table(DEPTH, 1'b1, 1'b1);
      run_lookups(150);
      end_phase();
   endtask

   task automatic test_clamped_count();
      write_count(COUNT_W'(DEPTH + 1));
      run_lookups(40);
      end_phase();
      write_count({COUNT_W{1'b1}});
      run_lookups(40);
      end_phase();
   endtask

   task automatic test_random_phases();
      int k;
      int n;
      for (int p = 0; p < 16; p++) begin
         k = $urandom_range(0, 9);
         n = (k == 0) ? 0 : (k == 1) ? $urandom_range(33, 100) : $urandom_range(1, 32);
         write_count(COUNT_W'(n));
         load_table((n == 0) ? 1 : n, bit'($urandom_range(0, 1)),
                    $urandom_range(0, 4) != 0);
         run_lookups(25);
         end_phase();
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_lookups.size() == 0) begin
            report_mismatch("result with no lookup outstanding");
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_data.result_y !== want.result_y) begin
               report_mismatch($sformatf("result_y %h, expected %h",
                                         rsp_data.result_y, want.result_y));
            end
            if (rsp_data.result_index !== want.result_index) begin
               report_mismatch($sformatf("result_index %0d, expected %0d",
                                         rsp_data.result_index, want.result_index));
            end
         end
      end
   end

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      count_reg = COUNT_W'(1);
      mismatch_count = 0;
      no_gaps = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_table();
      test_clamped_count();
      test_random_phases();
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("timeout");
      $display("*** FAILED ***");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/npl_pkg.sv
rtl/npl_ram.sv
rtl/npl_ctrl.sv
rtl/npl_datapath.sv
rtl/nearest_point_table_lookup_core.sv
dv/testbench.sv
